/* hw/rtl/efsd_pkg.sv */
// shared types and constants of the escaped frame sample decoder
package efsd_pkg;

  localparam int unsigned NumChannelsDefault = 8;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned ChanW   = 3;
  localparam int unsigned SampleW = 16;

  localparam logic [ByteW-1:0] ChOpen   = 8'h7B;
  localparam logic [ByteW-1:0] ChClose  = 8'h7D;
  localparam logic [ByteW-1:0] ChEscape = 8'h7C;
  localparam logic [ByteW-1:0] EscXor   = 8'h20;
  localparam logic [ByteW-1:0] ChTick   = 8'h74;

  typedef enum logic [KindW-1:0] {
    KIND_TICK  = 2'd0,
    KIND_CHAN  = 2'd1,
    KIND_PARAM = 2'd2
  } kind_e;

  typedef struct packed {
    logic                      valid;
    kind_e                     kind;
    logic [ChanW-1:0]          channel;
    logic signed [SampleW-1:0] sample;
  } result_t;

endpackage

/* hw/rtl/efsd_frame_decoder.sv */
// unstuffing, frame tracking and sample assembly for one byte per cycle while step_i is high
module efsd_frame_decoder #(
  parameter int unsigned NUM_CHANNELS = efsd_pkg::NumChannelsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [efsd_pkg::ByteW-1:0]   byte_i,
  input  logic                         pause_i,
  output efsd_pkg::result_t            result_o
);

  localparam logic [efsd_pkg::ByteW-1:0] NumCh = efsd_pkg::ByteW'(NUM_CHANNELS);

  logic                        esc_q, esc_d;
  logic                        in_frame_q, in_frame_d;
  logic [efsd_pkg::ByteW-1:0]  count_q, count_d;
  logic [efsd_pkg::ByteW-1:0]  high_q, high_d;

  logic                        is_data;
  logic [efsd_pkg::ByteW-1:0]  data;
  logic [efsd_pkg::ByteW-1:0]  idx;

  always_comb begin
    esc_d      = esc_q;
    in_frame_d = in_frame_q;
    count_d    = count_q;
    high_d     = high_q;
    is_data    = 1'b0;
    data       = byte_i;
    idx        = {1'b0, count_q[efsd_pkg::ByteW-1:1]} - 8'd1;
    result_o   = '0;
    result_o.kind = efsd_pkg::KIND_TICK;

    if (esc_q) begin
      esc_d   = 1'b0;
      is_data = 1'b1;
      data    = byte_i ^ efsd_pkg::EscXor;
    end else begin
      case (byte_i)
        efsd_pkg::ChClose:  in_frame_d = 1'b0;
        efsd_pkg::ChOpen: begin
          in_frame_d = 1'b1;
          count_d    = '0;
        end
        efsd_pkg::ChEscape: esc_d = 1'b1;
        default:            is_data = 1'b1;
      endcase
    end

    if (is_data && in_frame_q) begin
      count_d = count_q + 8'd1;
      if (count_q == '0) begin
        // first data byte of a frame must be the tick marker
        if (data != efsd_pkg::ChTick) begin
          in_frame_d = 1'b0;
        end else if (!pause_i) begin
          result_o.valid = 1'b1;
        end
      end else if (count_q[0]) begin
        high_d = data;
      end else if (idx < NumCh) begin
        result_o.valid   = 1'b1;
        result_o.kind    = efsd_pkg::KIND_CHAN;
        result_o.channel = idx[efsd_pkg::ChanW-1:0];
        result_o.sample  = {high_q, data};
      end else if (idx == NumCh) begin
        result_o.valid  = 1'b1;
        result_o.kind   = efsd_pkg::KIND_PARAM;
        result_o.sample = {high_q, data};
      end
    end

    if (!step_i) begin
      result_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q      <= 1'b0;
      in_frame_q <= 1'b0;
      count_q    <= '0;
      high_q     <= '0;
    end else if (step_i) begin
      esc_q      <= esc_d;
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
      high_q     <= high_d;
    end
  end

endmodule

/* hw/rtl/escaped_frame_sample_decoder_core.sv */
// top level of the escaped frame sample decoder: input and result registers
// Usage:
// Raw serial bytes enter on the s_axis channel, one byte per transaction.
// '{' opens a frame, '}' closes it and '|' escapes the next byte (xor 0x20).
// Each accepted frame starts with 't', which gives a time-tick event unless
// the pause bit is set; the following big-endian byte pairs give signed
// samples for channels 0..NUM_CHANNELS-1, then one parameter sample.
// Events leave on the m_axis channel: tuser carries the event kind, tdata the
// channel and the sample. A byte produces zero or one event.
// The pause bit is written through cfg_we_i/cfg_wdata_i; write it only while idle (not enforced by the block).
// From input transaction to event, the byte is first held in the input register,
// then the decode step loads the result register.
// Throughput is one byte per cycle unless the receiver stalls; the decode state updates in one step.
// When the receiver stalls with an event held, the input register holds too
// and s_axis_tready_o drops once it is occupied.
// Reset clears the frame state, both register valid bits and the pause bit.
module escaped_frame_sample_decoder_core #(
  parameter int unsigned NUM_CHANNELS = efsd_pkg::NumChannelsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,    // pause
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // [2:0] channel, [18:3] sample, rest zero
  output logic [1:0]  m_axis_tuser_o   // [1:0] event_kind
);

  logic                       pause_q;
  logic                       in_valid_q;
  logic [efsd_pkg::ByteW-1:0] in_byte_q;
  logic                       advance;
  logic                       step;
  efsd_pkg::result_t          result;
  efsd_pkg::result_t          out_q;

  assign advance         = !out_q.valid || m_axis_tready_i;
  assign step            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pause_q <= 1'b0;
    end else if (cfg_we_i) begin
      pause_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  efsd_frame_decoder #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_decoder (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .pause_i (pause_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (advance) begin
      out_q.valid <= result.valid;
      if (result.valid) begin
        out_q.kind    <= result.kind;
        out_q.channel <= result.channel;
        out_q.sample  <= result.sample;
      end
    end
  end

  assign m_axis_tvalid_o = out_q.valid;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {5'd0, out_q.sample, out_q.channel};

endmodule
